// ===== src/zone_text_escape_transcoder_core_assert.svh =====
// assertion macros shared by the transcoder modules
`ifndef ZONE_TEXT_ESCAPE_TRANSCODER_CORE_ASSERT_SVH
`define ZONE_TEXT_ESCAPE_TRANSCODER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`ifndef SYNTH
`define ZTE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("zte check failed: same-cycle implication");
`else
`define ZTE_ASSERT_IMP(name, clk, rst_n, ante, cons)
`endif

// next-cycle implication, checked outside reset
`ifndef SYNTH
`define ZTE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("zte check failed: next-cycle implication");
`else
`define ZTE_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/zte_pkg.sv =====
// shared types, constants and helpers for the zone text escape transcoder
`timescale 1ns / 1ps

package zte_pkg;

    // ascii codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // largest decoded decimal escape
    localparam logic [9:0] DEC_MAX = 10'd255;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TOO_LONG = 3'd1;
    localparam logic [2:0] ST_DANGLING = 3'd2;
    localparam logic [2:0] ST_BAD_DEC  = 3'd3;
    localparam logic [2:0] ST_DEC_BIG  = 3'd4;

    // command queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // escape sequence step of the last octal digit
    localparam logic [1:0] STEP_LAST = 2'd3;

    // one logical character or end marker, as handed from front to back
    typedef struct packed {
        logic       is_end;
        logic       esc;
        logic [7:0] value;
        logic [2:0] status;
        logic [7:0] length;
    } t_cmd;

    function automatic logic is_printable(input logic [7:0] v);
        return (v >= CH_SPACE) && (v <= CH_TILDE);
    endfunction

    function automatic logic is_digit(input logic [7:0] v);
        return (v >= CH_ZERO) && (v <= CH_NINE);
    endfunction

    function automatic logic needs_escape(input logic [7:0] v);
        return !is_printable(v) || (v == CH_COLON) || (v == CH_DOT) || (v == CH_BSLASH);
    endfunction

endpackage

// ===== src/zte_front.sv =====
// front end: accepts bytes, tracks escape state and pushes logical characters
`timescale 1ns / 1ps

module zte_front import zte_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    input  logic       i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_BSLASH = 2'd1;
    localparam logic [1:0] MODE_DIG1   = 2'd2;
    localparam logic [1:0] MODE_DIG2   = 2'd3;

    logic [1:0] r_mode, n_mode;
    logic [3:0] r_hund, n_hund;
    logic [3:0] r_tens, n_tens;
    logic [7:0] r_count, n_count;
    logic [2:0] r_err, n_err;
    logic [7:0] r_limit;

    logic       w_accept;
    logic       w_digit;
    logic [3:0] w_dval;
    logic [9:0] w_num;
    logic [7:0] w_count_inc;

    assign o_ready     = !i_full;
    assign w_accept    = i_valid && o_ready;
    assign w_digit     = is_digit(i_byte);
    assign w_dval      = i_byte[3:0];
    assign w_num       = 10'(r_hund) * 10'd100 + 10'(r_tens) * 10'd10 + 10'(w_dval);
    assign w_count_inc = r_count + 8'd1;

    always_comb begin
        n_mode  = r_mode;
        n_hund  = r_hund;
        n_tens  = r_tens;
        n_count = r_count;
        n_err   = r_err;
        o_push  = 1'b0;
        o_cmd   = '{is_end: 1'b0, esc: 1'b0, value: i_byte, status: ST_OK,
                    length: w_count_inc};
        if (w_accept) begin
            if (i_end) begin
                o_push       = 1'b1;
                o_cmd.is_end = 1'b1;
                o_cmd.value  = CH_NUL;
                o_cmd.length = r_count;
                o_cmd.status = r_err;
                if (r_err == ST_OK) begin
                    if (r_mode == MODE_BSLASH) begin
                        o_cmd.status = ST_DANGLING;
                    end else if (r_mode == MODE_DIG1 || r_mode == MODE_DIG2) begin
                        o_cmd.status = ST_BAD_DEC;
                    end
                end
                n_mode  = MODE_NORMAL;
                n_hund  = 4'd0;
                n_tens  = 4'd0;
                n_count = 8'd0;
                n_err   = ST_OK;
            end else if (r_err == ST_OK) begin
                unique case (r_mode)
                    MODE_NORMAL: begin
                        if (r_count >= r_limit) begin
                            n_err = ST_TOO_LONG;
                        end else if (i_byte == CH_BSLASH) begin
                            n_mode = MODE_BSLASH;
                        end else begin
                            o_push    = 1'b1;
                            o_cmd.esc = !is_printable(i_byte) || (i_byte == CH_COLON);
                            n_count   = w_count_inc;
                        end
                    end
                    MODE_BSLASH: begin
                        if (w_digit) begin
                            n_hund = w_dval;
                            n_mode = MODE_DIG1;
                        end else begin
                            n_mode    = MODE_NORMAL;
                            o_push    = 1'b1;
                            o_cmd.esc = needs_escape(i_byte);
                            n_count   = w_count_inc;
                        end
                    end
                    MODE_DIG1: begin
                        if (!w_digit) begin
                            n_err = ST_BAD_DEC;
                        end else begin
                            n_tens = w_dval;
                            n_mode = MODE_DIG2;
                        end
                    end
                    MODE_DIG2: begin
                        if (!w_digit) begin
                            n_err = ST_BAD_DEC;
                        end else if (w_num > DEC_MAX) begin
                            n_err = ST_DEC_BIG;
                        end else begin
                            n_mode      = MODE_NORMAL;
                            n_hund      = 4'd0;
                            n_tens      = 4'd0;
                            o_push      = 1'b1;
                            o_cmd.value = w_num[7:0];
                            o_cmd.esc   = needs_escape(w_num[7:0]);
                            n_count     = w_count_inc;
                        end
                    end
                    default: begin
                        n_mode = MODE_NORMAL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_hund  <= 4'd0;
            r_tens  <= 4'd0;
            r_count <= 8'd0;
            r_err   <= ST_OK;
            r_limit <= 8'd255;
        end else begin
            r_mode  <= n_mode;
            r_hund  <= n_hund;
            r_tens  <= n_tens;
            r_count <= n_count;
            r_err   <= n_err;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

endmodule

// ===== src/zte_fifo.sv =====
// short command queue between front and back
`timescale 1ns / 1ps

`include "zone_text_escape_transcoder_core_assert.svh"

module zte_fifo import zte_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    logic w_do_push;
    logic w_do_pop;

    assign o_full    = (r_count == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_head    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // a request pushed into a full queue would be lost
    `ZTE_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    // fill level stays within the depth
    `ZTE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1,
                    r_count <= (FIFO_AW + 1)'(FIFO_DEPTH))
    // pointers and fill level agree
    `ZTE_ASSERT_IMP(a_ptr_match, i_clk, i_rst_n, !o_full,
                    r_count[FIFO_AW-1:0] == (r_wr_ptr - r_rd_ptr))

endmodule

// ===== src/zte_back.sv =====
// back end: expands queued characters into result beats behind an output register
`timescale 1ns / 1ps

`include "zone_text_escape_transcoder_core_assert.svh"

module zte_back import zte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_head,
    input  logic        i_empty,
    output logic        o_pop,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [23:0] o_m_tdata,
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    logic [1:0] r_step;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_bvalid;
    logic       r_out_last;
    logic [2:0] r_out_status;
    logic [7:0] r_out_len;

    logic       w_load;
    logic       w_last_beat;
    logic [7:0] w_byte;

    assign w_load      = (!r_out_valid || i_m_tready) && !i_empty;
    assign w_last_beat = i_head.is_end || !i_head.esc || (r_step == STEP_LAST);
    assign o_pop       = w_load && w_last_beat;

    always_comb begin
        if (i_head.is_end) begin
            w_byte = CH_NUL;
        end else if (!i_head.esc) begin
            w_byte = i_head.value;
        end else begin
            unique case (r_step)
                2'd0:    w_byte = CH_BSLASH;
                2'd1:    w_byte = CH_ZERO + {6'd0, i_head.value[7:6]};
                2'd2:    w_byte = CH_ZERO + {5'd0, i_head.value[5:3]};
                default: w_byte = CH_ZERO + {5'd0, i_head.value[2:0]};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_step      <= w_last_beat ? 2'd0 : r_step + 2'd1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte   <= w_byte;
            r_out_bvalid <= !i_head.is_end;
            r_out_last   <= w_last_beat;
            r_out_status <= i_head.status;
            r_out_len    <= i_head.length;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_len, r_out_status, r_out_byte};
    assign o_m_tuser  = r_out_bvalid;
    assign o_m_tlast  = r_out_last;

    // a partly sent octal escape keeps its request at the queue head
    `ZTE_ASSERT_IMP(a_step_on_escape, i_clk, i_rst_n, r_step != 2'd0,
                    !i_empty && i_head.esc && !i_head.is_end)
    // a stalled result is not overwritten
    `ZTE_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_m_tready, !w_load)

endmodule

// ===== src/zone_text_escape_transcoder_core.sv =====
// top level of the zone text escape transcoder
//
//  channel   dir  handshake              payload
//  --------  ---  ---------------------  -------------------------------------------
//  s stream  in   i_s_tvalid/o_s_tready  tdata: char_byte; tlast: end_of_string
//  m stream  out  o_m_tvalid/i_m_tready  tdata: out_byte, status, length; tuser: byte_valid
//  cfg       in   i_cfg_we               i_cfg_wdata: length_limit
//
//  a plain character or end marker gives one result beat, an octal escape gives four;
//  the back end sends one beat per cycle while i_m_tready is high and a request is queued
//  silent bytes (backslash, escape digits, errors, bytes after an error) give no result beat
//  input reaches its first result through the command queue and the output register
//  a four-entry request queue lets the front keep accepting while the back stalls
//  synchronous active-low reset clears escape state, counters, queue and output valid;
//  length_limit resets to 255
`timescale 1ns / 1ps

module zone_text_escape_transcoder_core import zte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: length_limit
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_byte
    input  logic        i_s_tlast,   // end_of_string
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] out_byte, [10:8] status, [18:11] logical_length
    output logic        o_m_tuser,   // [0] byte_valid
    output logic        o_m_tlast    // run_last
);

    // front to queue
    logic w_push;
    t_cmd w_push_cmd;
    logic w_full;

    // queue to back
    t_cmd w_head;
    logic w_empty;
    logic w_pop;

    // byte classification, escape decoding and length check
    zte_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_tvalid),
        .i_byte      (i_s_tdata),
        .i_end       (i_s_tlast),
        .i_full      (w_full),
        .o_ready     (o_s_tready),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    // decouples the front from output back-pressure
    zte_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_full     (w_full),
        .o_empty    (w_empty)
    );

    // expands each request into one or four result beats
    zte_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
